// ===== hw/rtl/bbc_pkg.sv =====
`timescale 1ns / 1ps

package bbc_pkg;

  // Character codes of interest.
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Codes of the expected closer held in each stack cell.
  localparam logic [1:0] CODE_PAREN  = 2'd0;
  localparam logic [1:0] CODE_SQUARE = 2'd1;
  localparam logic [1:0] CODE_BRACE  = 2'd2;

  localparam int OUT_W = 16;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic             is_balanced;
    logic [OUT_W-1:0] error_line;
    logic [OUT_W-1:0] error_column;
    logic             depth_overflow;
  } out_beat_t;

  // Shift control shared by every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

  // Control of the position counters.
  typedef struct packed {
    logic step;
    logic newline;
    logic clear;
  } pos_ctl_t;

endpackage

// ===== hw/rtl/bracket_balance_checker_unit.sv =====
`timescale 1ns / 1ps
// A result is registered onto out_* in the cycle after its last beat is accepted.
// Throughput: one beat per cycle; each beat makes at most one push or pop of the cell chain.
// A last beat is held off only while an earlier result is still stalled at the output.
// Reset (rst_n low, synchronous): empty stack, line 1, column 0, no result pending.
// The stack cells themselves are not reset; only entries below the fill count are read.
module bracket_balance_checker_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bbc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bbc_pkg::out_beat_t out_data
);

  // Fill count wide enough to hold the depth itself.
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  // Width used to compare the counters against the 16-bit report limit.
  localparam int XW    = (COUNT_WIDTH > bbc_pkg::OUT_W) ? COUNT_WIDTH : bbc_pkg::OUT_W;
  localparam logic [XW-1:0] REPORT_MAX = XW'(16'hFFFF);

  // Output register, declared here because the input handshake looks at it.
  logic               out_valid_r;
  bbc_pkg::out_beat_t out_data_r;

  // Input handshake. A beat that does not end a text can always be taken,
  // since it produces no result; only a last beat must wait for the output
  // register to be free.
  logic in_acc;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !out_free && in_data.last_byte;
  assign in_acc   = in_valid && !in_stall;

  // Decode of the incoming character.
  logic       is_opener;
  logic       is_closer;
  logic [1:0] byte_code;

  always_comb begin
    is_opener = 1'b0;
    is_closer = 1'b0;
    byte_code = bbc_pkg::CODE_PAREN;
    case (in_data.text_byte)
      bbc_pkg::CH_LPAREN: begin
        is_opener = 1'b1;
        byte_code = bbc_pkg::CODE_PAREN;
      end
      bbc_pkg::CH_LSQUARE: begin
        is_opener = 1'b1;
        byte_code = bbc_pkg::CODE_SQUARE;
      end
      bbc_pkg::CH_LBRACE: begin
        is_opener = 1'b1;
        byte_code = bbc_pkg::CODE_BRACE;
      end
      bbc_pkg::CH_RPAREN: begin
        is_closer = 1'b1;
        byte_code = bbc_pkg::CODE_PAREN;
      end
      bbc_pkg::CH_RSQUARE: begin
        is_closer = 1'b1;
        byte_code = bbc_pkg::CODE_SQUARE;
      end
      bbc_pkg::CH_RBRACE: begin
        is_closer = 1'b1;
        byte_code = bbc_pkg::CODE_BRACE;
      end
      default: begin
        is_opener = 1'b0;
      end
    endcase
  end

  // Stack bookkeeping. Once a fault has been latched the text is only
  // scanned for its last beat, so nothing moves.
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             error_r;
  logic             error_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  logic             live;
  logic             stack_empty;
  logic             stack_full;
  logic [1:0]       top_code;
  bbc_pkg::shift_ctl_t shift;

  assign live        = in_acc && !error_r;
  assign stack_empty = (count_r == '0);
  assign stack_full  = (count_r == CNT_W'(STACK_DEPTH));

  always_comb begin
    count_nxt  = count_r;
    error_nxt  = error_r;
    ovf_nxt    = ovf_r;
    shift.push = 1'b0;
    shift.pop  = 1'b0;
    if (live) begin
      if (is_opener) begin
        if (stack_full) begin
          // No room for another opener: this is a fault at its own position.
          ovf_nxt   = 1'b1;
          error_nxt = 1'b1;
        end else begin
          shift.push = 1'b1;
          count_nxt  = count_r + 1'b1;
        end
      end else if (is_closer) begin
        // A closer must match the top of the stack, which is always cell 0.
        if (stack_empty || (top_code != byte_code)) begin
          error_nxt = 1'b1;
        end else begin
          shift.pop = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_data.last_byte)) begin
      count_r <= '0;
      error_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      error_r <= error_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // The stack is a chain of cells: cell 0 is the top. A push moves every
  // entry one cell down and loads the new code into cell 0; a pop moves
  // every entry one cell up. The bottom cell simply holds on a pop.
  logic [1:0] cell_code [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [1:0] up_code;
    logic [1:0] down_code;

    if (i == 0) begin : g_top
      assign up_code = byte_code;
    end else begin : g_mid_up
      assign up_code = cell_code[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign down_code = cell_code[i];
    end else begin : g_mid_down
      assign down_code = cell_code[i+1];
    end

    bbc_cell u_cell (
      .clk       (clk),
      .ctl       (shift),
      .up_code   (up_code),
      .down_code (down_code),
      .code      (cell_code[i])
    );
  end

  assign top_code = cell_code[0];

  // Position counters advance on every live beat.
  bbc_pkg::pos_ctl_t      pos_ctl;
  logic [COUNT_WIDTH-1:0] line_nxt;
  logic [COUNT_WIDTH-1:0] column_nxt;

  assign pos_ctl.step    = live;
  assign pos_ctl.newline = (in_data.text_byte == bbc_pkg::CH_NEWLINE);
  assign pos_ctl.clear   = in_acc && in_data.last_byte;

  bbc_pos #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pos_ctl),
    .line_nxt   (line_nxt),
    .column_nxt (column_nxt)
  );

  // Counters wider than the report are clamped rather than wrapped.
  logic [XW-1:0] line_ext;
  logic [XW-1:0] column_ext;
  logic [15:0]   line_rep;
  logic [15:0]   column_rep;

  assign line_ext   = XW'(line_nxt);
  assign column_ext = XW'(column_nxt);
  assign line_rep   = (line_ext > REPORT_MAX) ? 16'hFFFF : line_ext[15:0];
  assign column_rep = (column_ext > REPORT_MAX) ? 16'hFFFF : column_ext[15:0];

  // Output register. It loads the result of a last beat, and it is free
  // whenever it is empty or its current result is being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_acc && in_data.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.last_byte) begin
      out_data_r.is_balanced    <= !error_nxt && (count_nxt == '0);
      out_data_r.error_line     <= line_rep;
      out_data_r.error_column   <= column_rep;
      out_data_r.depth_overflow <= ovf_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/bbc_cell.sv =====
`timescale 1ns / 1ps

// One entry of the closer stack. On a push it takes the code of the cell
// above it, on a pop the code of the cell below it.
module bbc_cell (
  input  logic                clk,
  input  bbc_pkg::shift_ctl_t ctl,
  input  logic [1:0]          up_code,
  input  logic [1:0]          down_code,
  output logic [1:0]          code
);

  logic [1:0] code_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      code_r <= up_code;
    end else if (ctl.pop) begin
      code_r <= down_code;
    end
  end

  assign code = code_r;

endmodule

// ===== hw/rtl/bbc_pos.sv =====
`timescale 1ns / 1ps

// Saturating line and column counters.
module bbc_pos #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bbc_pkg::pos_ctl_t      ctl,
  output logic [COUNT_WIDTH-1:0] line_nxt,
  output logic [COUNT_WIDTH-1:0] column_nxt
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] line_r;
  logic [COUNT_WIDTH-1:0] column_r;

  always_comb begin
    line_nxt   = line_r;
    column_nxt = column_r;
    if (ctl.step) begin
      if (ctl.newline) begin
        column_nxt = '0;
        line_nxt   = (line_r == CNT_MAX) ? line_r : line_r + 1'b1;
      end else begin
        column_nxt = (column_r == CNT_MAX) ? column_r : column_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      line_r   <= COUNT_WIDTH'(1);
      column_r <= '0;
    end else begin
      line_r   <= line_nxt;
      column_r <= column_nxt;
    end
  end

endmodule

// ===== hw/rtl/bbc_checker.sv =====
`timescale 1ns / 1ps

module bbc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bbc_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bbc_pkg::out_beat_t out_data
);

  // A stalled result stays on offer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Every accepted last beat yields a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_byte |=> out_valid)
    else $error("last beat produced no result");

  // No result appears from nothing.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && !in_stall && in_data.last_byte) |=> !out_valid)
    else $error("result without a last beat");

  // A text that overflowed the stack is never reported balanced.
  a_ovf_unbalanced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_balanced && out_data.depth_overflow))
    else $error("balanced result with overflow");

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (.*);

// ===== test/bracket_balance_checker_unit_test.sv =====
`timescale 1ns / 1ps

module bracket_balance_checker_unit_test;

  // The block is built with its default sizes, and the predictor uses the same ones.
  localparam int DEPTH = 64;
  localparam int CNT_W = 16;
  localparam logic [15:0] CNT_TOP = 16'hFFFF;

  localparam int RANDOM_BEATS = 480;
  localparam int HOLD_CYCLES = 300;

  // The slowest correct run is some seven hundred beats, each waiting out random idle
  // gaps on each side, and one long hold-off. The limit is set well above what that
  // run needs.
  localparam longint CYCLE_LIMIT = 500_000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  bbc_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_stall;
  bbc_pkg::out_beat_t out_data;

  bracket_balance_checker_unit #(
    .STACK_DEPTH(DEPTH),
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 8 ns period.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // The bracket characters and the newline, used to make noisy texts dense in them.
  localparam logic [7:0] MARKS [7] = '{
    bbc_pkg::CH_LPAREN, bbc_pkg::CH_RPAREN, bbc_pkg::CH_LSQUARE, bbc_pkg::CH_RSQUARE,
    bbc_pkg::CH_LBRACE, bbc_pkg::CH_RBRACE, bbc_pkg::CH_NEWLINE
  };

  // One row of the directed script. Where a row ends a text and its result is plain to
  // see, the result is written out here; otherwise the predictor supplies it.
  typedef struct packed {
    logic [7:0]         ch;
    logic               last;
    logic               fixed;
    bbc_pkg::out_beat_t res;
  } script_row_t;

  localparam int SCRIPT_N = 18;
  localparam script_row_t SCRIPT [SCRIPT_N] = '{
    // A simple matched pair.
    '{bbc_pkg::CH_LPAREN,  1'b0, 1'b0, '0},
    '{bbc_pkg::CH_RPAREN,  1'b1, 1'b1, '{1'b1, 16'd1, 16'd2, 1'b0}},
    // Nesting of two different kinds.
    '{bbc_pkg::CH_LSQUARE, 1'b0, 1'b0, '0},
    '{bbc_pkg::CH_LBRACE,  1'b0, 1'b0, '0},
    '{bbc_pkg::CH_RBRACE,  1'b0, 1'b0, '0},
    '{bbc_pkg::CH_RSQUARE, 1'b1, 1'b1, '{1'b1, 16'd1, 16'd4, 1'b0}},
    // A closer of the wrong kind is a fault at its own column.
    '{bbc_pkg::CH_LPAREN,  1'b0, 1'b0, '0},
    '{bbc_pkg::CH_RSQUARE, 1'b1, 1'b1, '{1'b0, 16'd1, 16'd2, 1'b0}},
    // A closer with nothing open.
    '{bbc_pkg::CH_RBRACE,  1'b1, 1'b1, '{1'b0, 16'd1, 16'd1, 1'b0}},
    // An opener left unclosed reports the final position, here on the second line.
    '{bbc_pkg::CH_LBRACE,  1'b0, 1'b0, '0},
    '{bbc_pkg::CH_NEWLINE, 1'b0, 1'b0, '0},
    '{8'h78,               1'b1, 1'b1, '{1'b0, 16'd2, 16'd1, 1'b0}},
    // After a fault the position freezes and later brackets are ignored.
    '{bbc_pkg::CH_RPAREN,  1'b0, 1'b0, '0},
    '{bbc_pkg::CH_LPAREN,  1'b0, 1'b0, '0},
    '{8'hFF,               1'b1, 1'b1, '{1'b0, 16'd1, 16'd1, 1'b0}},
    // One-character texts at the extremes of the byte, and a lone newline.
    '{8'h00,               1'b1, 1'b1, '{1'b1, 16'd1, 16'd1, 1'b0}},
    '{8'hFF,               1'b1, 1'b1, '{1'b1, 16'd1, 16'd1, 1'b0}},
    '{bbc_pkg::CH_NEWLINE, 1'b1, 1'b1, '{1'b1, 16'd2, 16'd0, 1'b0}}
  };

  // Predictor state: the closers still owed, the position and the latched faults.
  logic [1:0]  owed_closer [DEPTH];
  int          owed_n;
  logic [15:0] line_no;
  logic [15:0] col_no;
  bit          fault_seen;
  bit          overflow_seen;

  bbc_pkg::out_beat_t verdict_q [$];
  logic [7:0]         text_q [$];

  int          mismatches = 0;
  longint      cycle_no = 0;
  bit          calm;
  bit          hold_off_req;
  int          beats_sent;

  function automatic void restart_text();
    owed_n        = 0;
    line_no       = 16'd1;
    col_no        = 16'd0;
    fault_seen    = 1'b0;
    overflow_seen = 1'b0;
  endfunction

  // Mostly short gaps, some a little longer and now and then a long one.
  // During calm stretches neither side idles at all, save for the receiver's one hold-off.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Advances the predictor by one beat. On a last beat it hands back the verdict
  // for the whole text and starts afresh for the next one.
  task automatic track_beat(input logic [7:0] ch, input logic last,
                            output bit done, output bbc_pkg::out_beat_t res);
    bit         is_open;
    bit         is_close;
    logic [1:0] code;
    is_open  = 1'b0;
    is_close = 1'b0;
    code     = bbc_pkg::CODE_PAREN;
    res      = '0;
    if (!fault_seen) begin
      if (col_no != CNT_TOP) col_no++;
      if (ch == bbc_pkg::CH_NEWLINE) begin
        if (line_no != CNT_TOP) line_no++;
        col_no = 16'd0;
      end
      case (ch)
        bbc_pkg::CH_LPAREN:  begin is_open  = 1'b1; code = bbc_pkg::CODE_PAREN;  end
        bbc_pkg::CH_LSQUARE: begin is_open  = 1'b1; code = bbc_pkg::CODE_SQUARE; end
        bbc_pkg::CH_LBRACE:  begin is_open  = 1'b1; code = bbc_pkg::CODE_BRACE;  end
        bbc_pkg::CH_RPAREN:  begin is_close = 1'b1; code = bbc_pkg::CODE_PAREN;  end
        bbc_pkg::CH_RSQUARE: begin is_close = 1'b1; code = bbc_pkg::CODE_SQUARE; end
        bbc_pkg::CH_RBRACE:  begin is_close = 1'b1; code = bbc_pkg::CODE_BRACE;  end
        default: ;
      endcase
      if (is_open) begin
        if (owed_n >= DEPTH) begin
          overflow_seen = 1'b1;
          fault_seen    = 1'b1;
        end else begin
          owed_closer[owed_n] = code;
          owed_n++;
        end
      end else if (is_close) begin
        if (owed_n == 0 || owed_closer[owed_n-1] != code) fault_seen = 1'b1;
        else owed_n--;
      end
    end
    done = last;
    if (last) begin
      res.is_balanced    = !fault_seen && owed_n == 0;
      res.error_line     = line_no;
      res.error_column   = col_no;
      res.depth_overflow = overflow_seen;
      restart_text();
    end
  endtask

  // Offers one beat, waits for it to be taken, and records what it should produce.
  // Entered and left at a falling edge, so that each input changes once per step.
  task automatic send_beat(input logic [7:0] ch, input logic last,
                           input bit fixed, input bbc_pkg::out_beat_t fixed_res);
    int                 gap;
    bit                 done;
    bbc_pkg::out_beat_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= '{text_byte: ch, last_byte: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    track_beat(ch, last, done, pred);
    if (done) verdict_q.push_back(fixed ? fixed_res : pred);
    beats_sent++;
    @(negedge clk);
  endtask

  // Sends the text built up in text_q, marking its final character as the last beat.
  task automatic send_text();
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) send_beat(text_q[i], i == n - 1, 1'b0, '0);
    text_q.delete();
  endtask

  function automatic logic [7:0] opener_of(int k);
    return (k == 0) ? bbc_pkg::CH_LPAREN : (k == 1) ? bbc_pkg::CH_LSQUARE :
                      bbc_pkg::CH_LBRACE;
  endfunction

  function automatic logic [7:0] closer_of(int k);
    return (k == 0) ? bbc_pkg::CH_RPAREN : (k == 1) ? bbc_pkg::CH_RSQUARE :
                      bbc_pkg::CH_RBRACE;
  endfunction

  // Builds one random text. Most are well nested with random filler, so that they get
  // past the first bracket; some are then broken in one place. The rest are noise
  // thick with brackets, or nestings that go close to the stack depth or past it.
  task automatic build_text();
    logic [7:0] owed [$];
    int         mode;
    int         len;
    int         r;
    int         k;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          k = $urandom_range(0, 2);
          text_q.push_back(opener_of(k));
          owed.push_back(closer_of(k));
        end else if (r < 6 && owed.size() > 0) begin
          text_q.push_back(owed.pop_back());
        end else if (r == 6) begin
          text_q.push_back(bbc_pkg::CH_NEWLINE);
        end else begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      // Leave the outermost opener unclosed now and then.
      if (owed.size() > 0 && $urandom_range(0, 9) == 0) void'(owed.pop_front());
      while (owed.size() > 0) text_q.push_back(owed.pop_back());
      // And now and then put a stray bracket somewhere.
      if ($urandom_range(0, 9) == 0)
        text_q[$urandom_range(0, text_q.size() - 1)] = MARKS[$urandom_range(0, 5)];
    end else if (mode < 94) begin
      len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) < 6) text_q.push_back(MARKS[$urandom_range(0, 6)]);
        else text_q.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      len = $urandom_range(DEPTH - 6, DEPTH + 4);
      for (int i = 0; i < len; i++) begin
        k = $urandom_range(0, 2);
        text_q.push_back(opener_of(k));
        owed.push_back(closer_of(k));
      end
      if ($urandom_range(0, 1) == 0) len = owed.size();
      else len = $urandom_range(0, owed.size());
      for (int i = 0; i < len; i++) text_q.push_back(owed.pop_back());
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // The receiver. It stalls in random stretches, and once, on request, holds off for a
  // long stretch of its own counting while the sender keeps offering texts.
  initial begin : result_side
    int n;
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // Every result taken is compared field by field with the oldest verdict waiting.
  always @(posedge clk) begin : result_check
    bbc_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("result arrived with no verdict waiting");
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.is_balanced !== want.is_balanced) begin
          $error("is_balanced: expected %0d, actual %0d", want.is_balanced,
                 out_data.is_balanced);
          mismatches++;
        end
        if (out_data.error_line !== want.error_line) begin
          $error("error_line: expected %0d, actual %0d", want.error_line,
                 out_data.error_line);
          mismatches++;
        end
        if (out_data.error_column !== want.error_column) begin
          $error("error_column: expected %0d, actual %0d", want.error_column,
                 out_data.error_column);
          mismatches++;
        end
        if (out_data.depth_overflow !== want.depth_overflow) begin
          $error("depth_overflow: expected %0d, actual %0d", want.depth_overflow,
                 out_data.depth_overflow);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : text_side
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    beats_sent   = 0;
    restart_text();

    // Reset is held across rising edges of the clock and released at a falling one.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed script.
    for (int i = 0; i < SCRIPT_N; i++)
      send_beat(SCRIPT[i].ch, SCRIPT[i].last, SCRIPT[i].fixed, SCRIPT[i].res);

    // A stack filled to the brim and emptied again, then one opener too many.
    for (int i = 0; i < DEPTH; i++) text_q.push_back(opener_of(i % 3));
    for (int i = DEPTH - 1; i >= 0; i--) text_q.push_back(closer_of(i % 3));
    send_text();
    for (int i = 0; i <= DEPTH; i++) text_q.push_back(bbc_pkg::CH_LBRACE);
    text_q.push_back(bbc_pkg::CH_RBRACE);
    send_text();

    // Back pressure: the receiver holds off while short texts keep coming, so the
    // pending result blocks the next last beat and the input stalls.
    calm = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      text_q.push_back(MARKS[$urandom_range(0, 6)]);
      if (i % 2 == 0) text_q.push_back(8'($urandom_range(0, 255)));
      send_text();
    end
    calm = 1'b0;

    // Random texts, with the odd stretch in which neither side idles.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      calm = ($urandom_range(0, 9) == 0);
      build_text();
      send_text();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain: every verdict must be matched, then the bench keeps watching for strays.
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
